// ===== rtl/sssvh_pkg.sv =====
`default_nettype none
package sssvh_pkg;
    localparam int GridWidth   = 64;
    localparam int GridHeight  = 64;
    localparam int GridDepth   = 64;
    localparam int CountBits   = 20;
    localparam int ColBits     = $clog2(GridWidth);
    localparam int RowBits     = $clog2(GridHeight);
    localparam int SlcBits     = $clog2(GridDepth);
    localparam int AddrBits    = ColBits + RowBits + SlcBits;
    localparam int Cells       = GridWidth * GridHeight * GridDepth;
    localparam int CordicSteps = 30;
    localparam int StepBits    = 5;
    localparam logic [33:0] CordicGain = 34'd652032874;
    localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

    typedef enum logic {
        t_ACT_SAMPLE = 1'b0,
        t_ACT_READ   = 1'b1
    } t_action;

    localparam logic [0:0] RegRadius = 1'b0;

    // Arctangent of 2^-i, with one turn equal to 2^32.
    function automatic logic [31:0] atan_turn(input logic [StepBits-1:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h20000000; 5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B; 5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43; 5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E; 5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53; 5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98; 5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6; 5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA; 5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE; 5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30; 5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C; 5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3; 5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029; 5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A; 5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003; 5'd29: v = 32'h00000001;
            default: v = 32'h0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/sssvh_if.sv =====
`default_nettype none
interface sssvh_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [31:0] uniform_height;
    logic [31:0] uniform_angle;
    logic [17:0] voxel_address;
    modport source (output valid, action, uniform_height, uniform_angle, voxel_address,
                    input ready);
    modport sink (input valid, action, uniform_height, uniform_angle, voxel_address,
                  output ready);
endinterface

interface sssvh_out_if;
    logic        valid;
    logic        ready;
    logic signed [21:0] point_x;
    logic signed [21:0] point_y;
    logic signed [21:0] point_z;
    logic [5:0]  voxel_column;
    logic [5:0]  voxel_row;
    logic [5:0]  voxel_slice;
    logic [19:0] voxel_count;
    modport source (output valid, point_x, point_y, point_z, voxel_column, voxel_row,
                    voxel_slice, voxel_count, input ready);
    modport sink (input valid, point_x, point_y, point_z, voxel_column, voxel_row,
                  voxel_slice, voxel_count, output ready);
endinterface
`default_nettype wire

// ===== rtl/sphere_surface_sampler_voxel_histogram_top.sv =====
// Channel   Direction  Payload
// in        sink       action, uniform_height, uniform_angle, voxel_address
// out       source     point x/y/z, voxel column/row/slice, voxel_count
// apb       slave      radius_scale at byte address 0
//
// A sample transaction runs from acceptance through a load step, 32 square-root
// steps and a finishing step, 30 CORDIC steps, the quadrant fold, two products on
// one shared multiplier, three scale steps, the index, and the histogram read,
// wait, write and output steps. A read transaction runs through read, wait,
// write slot and output. The sequencer returns to idle before it accepts the
// next transaction. After reset a clearing pass writes zero to all 262144
// histogram entries, one per cycle; no transaction is accepted meanwhile. The
// next transaction is accepted while a result waits in the output register; it
// stalls in its output step until that result has been taken.
`default_nettype none
module sphere_surface_sampler_voxel_histogram_top
    import sssvh_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    sssvh_in_if.sink    i_in,
    sssvh_out_if.source o_out,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [1:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    typedef enum logic [3:0] {
        t_CLEAR, t_IDLE, t_SQRT, t_CORDIC, t_MULX, t_MULY, t_SCALE,
        t_INDEX, t_RD, t_WAIT, t_WR, t_EMIT
    } t_state;

    t_state r_state;
    logic [4:0]  r_radius;
    logic [AddrBits:0] r_clr;
    logic        r_act;
    logic [AddrBits-1:0] r_addr;
    logic        r_oor;
    // Square-root datapath
    logic [63:0] r_rem, r_root, r_bit;
    logic signed [33:0] r_cq;
    // CORDIC datapath
    logic signed [33:0] r_cx, r_cy;
    logic signed [33:0] r_cz;
    logic [1:0]  r_quad;
    logic [StepBits-1:0] r_step;
    logic signed [33:0] r_cs, r_sn;
    logic signed [34:0] r_px, r_py, r_pz;
    logic [ColBits-1:0] r_col;
    logic [RowBits-1:0] r_row;
    logic [SlcBits-1:0] r_slc;
    logic [CountBits-1:0] r_cnt;
    // Histogram memory
    logic [CountBits-1:0] r_mem [Cells];
    logic [CountBits-1:0] r_rdata;
    // Output register
    logic        r_ovalid;
    logic signed [21:0] r_ox, r_oy, r_oz;
    logic [5:0]  r_ocol, r_orow, r_oslc;
    logic [19:0] r_ocnt;

    logic        w_acc;
    logic        w_free;
    logic signed [34:0] w_cxs, w_cys;
    logic signed [33:0] w_dz;
    logic signed [67:0] w_prod;
    logic signed [40:0] w_scaled;
    logic signed [34:0] w_lim;
    logic [31:0] w_mag;
    logic [63:0] w_sq;

    assign pready = 1'b1;
    assign prdata = (paddr[1:0] == 2'd0) ? {27'd0, r_radius} : 32'd0;

    assign w_free = !r_ovalid || o_out.ready;
    assign i_in.ready = (r_state == t_IDLE);
    assign w_acc = i_in.valid && i_in.ready;
    assign w_cxs = r_cx >>> r_step;
    assign w_cys = r_cy >>> r_step;
    assign w_dz = {1'b0, atan_turn(r_step), 1'b0};
    assign w_lim = {14'd0, r_radius, 16'd0};
    // One multiplier serves both products: cosine first, then sine.
    assign w_prod = $signed({1'b0, r_root[32:0]}) * ((r_step == '0) ? r_cs : r_sn);
    assign w_scaled = $signed(r_px) * $signed({1'b0, r_radius});
    // Magnitude of the height and its square for the square-root operand.
    assign w_mag = r_cq[33] ? 32'(-r_cq) : r_cq[31:0];
    assign w_sq = 64'(w_mag) * 64'(w_mag);

    assign o_out.valid = r_ovalid;
    assign o_out.point_x = r_ox;
    assign o_out.point_y = r_oy;
    assign o_out.point_z = r_oz;
    assign o_out.voxel_column = r_ocol;
    assign o_out.voxel_row = r_orow;
    assign o_out.voxel_slice = r_oslc;
    assign o_out.voxel_count = r_ocnt;

    // Clamp to +-limit, then floor index with clamp to grid.
    function automatic logic signed [34:0] clampr(input logic signed [34:0] v,
                                                  input logic signed [34:0] lim);
        logic signed [34:0] r;
        r = v;
        if (v > lim) r = lim;
        if (v < -lim) r = -lim;
        return r;
    endfunction

    function automatic logic [7:0] gidx(input logic signed [34:0] v, input int sz);
        logic signed [34:0] f;
        f = v >>> 16;
        if (f < 0) return 8'd0;
        if (f > 35'(sz - 1)) return 8'(sz - 1);
        return f[7:0];
    endfunction

    // Memory port: one write per cycle, registered read
    always_ff @(posedge i_clk) begin
        if (r_state == t_CLEAR) begin
            r_mem[r_clr[AddrBits-1:0]] <= '0;
        end else if (r_state == t_WR && r_act == t_ACT_SAMPLE) begin
            r_mem[r_addr] <= r_cnt;
        end
        r_rdata <= r_mem[r_addr];
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= 5'd20;
        end else if (psel && penable && pwrite && paddr == 2'd0) begin
            r_radius <= pwdata[4:0];
        end
    end

    // Sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_CLEAR;
            r_clr <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && o_out.ready && r_state != t_EMIT) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                t_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr[AddrBits-1:0] == {AddrBits{1'b1}}) begin
                        r_state <= t_IDLE;
                    end
                end
                t_IDLE: begin
                    if (w_acc) begin
                        r_act <= i_in.action;
                        if (i_in.action == t_ACT_READ) begin
                            r_addr <= i_in.voxel_address[AddrBits-1:0];
                            r_oor <= 1'b0;
                            r_col <= i_in.voxel_address[ColBits-1:0];
                            r_row <= i_in.voxel_address[ColBits+RowBits-1:ColBits];
                            r_slc <= i_in.voxel_address[AddrBits-1:ColBits+RowBits];
                            r_px <= '0;
                            r_py <= '0;
                            r_pz <= '0;
                            r_state <= t_RD;
                        end else begin
                            r_cq <= $signed({1'b0, i_in.uniform_height, 1'b1})
                                    - $signed(34'h100000000);
                            r_rem <= '0;
                            r_bit <= 64'h4000000000000000;
                            r_root <= '0;
                            r_cx <= $signed(CordicGain);
                            r_cy <= '0;
                            r_cz <= $signed({3'b0, i_in.uniform_angle[29:0], 1'b1});
                            r_quad <= i_in.uniform_angle[31:30];
                            r_step <= '0;
                            r_state <= t_SQRT;
                        end
                    end
                end
                t_SQRT: begin
                    // First cycle loads 2^64 - cq^2; step stays at 0 then.
                    if (r_step == '0 && r_bit == 64'h4000000000000000 && r_root == '0
                        && r_rem == '0) begin
                        r_rem <= 64'd0 - w_sq;
                        r_root <= 64'd1;
                    end else if (r_bit != 0) begin
                        if (r_rem >= (r_root[0] ? 64'd0 : r_root) + r_bit) begin
                            r_rem <= r_rem - ((r_root[0] ? 64'd0 : r_root) + r_bit);
                            r_root <= ((r_root[0] ? 64'd0 : r_root) >> 1) + r_bit;
                        end else begin
                            r_root <= (r_root[0] ? 64'd0 : r_root) >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end else begin
                        r_state <= t_CORDIC;
                    end
                end
                t_CORDIC: begin
                    if (r_cz >= 0) begin
                        r_cx <= r_cx - w_cys[33:0];
                        r_cy <= r_cy + w_cxs[33:0];
                        r_cz <= r_cz - w_dz;
                    end else begin
                        r_cx <= r_cx + w_cys[33:0];
                        r_cy <= r_cy - w_cxs[33:0];
                        r_cz <= r_cz + w_dz;
                    end
                    r_step <= r_step + 1'b1;
                    if (r_step == StepBits'(CordicSteps - 1)) begin
                        r_state <= t_MULX;
                    end
                end
                t_MULX: begin
                    case (r_quad)
                        2'd0: begin r_cs <= r_cx; r_sn <= r_cy; end
                        2'd1: begin r_cs <= -r_cy; r_sn <= r_cx; end
                        2'd2: begin r_cs <= -r_cx; r_sn <= -r_cy; end
                        default: begin r_cs <= r_cy; r_sn <= -r_cx; end
                    endcase
                    r_state <= t_MULY;
                    r_step <= '0;
                end
                t_MULY: begin
                    // Two products on the shared multiplier, one per cycle.
                    if (r_step == '0) begin
                        r_px <= 35'((w_prod + 68'sh80000000) >>> 32);
                        r_step <= 5'd1;
                    end else begin
                        r_py <= 35'((w_prod + 68'sh80000000) >>> 32);
                        r_step <= '0;
                        r_state <= t_SCALE;
                    end
                end
                t_SCALE: begin
                    if (r_step == '0) begin
                        r_px <= clampr(35'((w_scaled + 41'sd8192) >>> 14), w_lim);
                        r_step <= 5'd1;
                    end else if (r_step == 5'd1) begin
                        r_py <= clampr(35'(($signed(r_py) * $signed({1'b0, r_radius})
                                        + 41'sd8192) >>> 14), w_lim);
                        r_step <= 5'd2;
                    end else begin
                        r_pz <= clampr(35'(($signed(r_cq) * $signed({1'b0, r_radius})
                                        + 41'sd32768) >>> 16), w_lim);
                        r_state <= t_INDEX;
                    end
                end
                t_INDEX: begin
                    r_col <= ColBits'(gidx(r_px + 35'((GridWidth - 1) * 32768), GridWidth));
                    r_row <= RowBits'(gidx(35'((GridHeight - 1) * 32768) - r_py,
                                           GridHeight));
                    r_slc <= SlcBits'(gidx(35'((GridDepth - 1) * 32768) - r_pz, GridDepth));
                    r_addr <= {SlcBits'(gidx(35'((GridDepth - 1) * 32768) - r_pz, GridDepth)),
                               RowBits'(gidx(35'((GridHeight - 1) * 32768) - r_py,
                                             GridHeight)),
                               ColBits'(gidx(r_px + 35'((GridWidth - 1) * 32768),
                                             GridWidth))};
                    r_state <= t_RD;
                end
                t_RD: begin
                    r_state <= t_WAIT;
                end
                t_WAIT: begin
                    if (r_act == t_ACT_SAMPLE && r_rdata != CountMax) begin
                        r_cnt <= r_rdata + 1'b1;
                    end else begin
                        r_cnt <= r_rdata;
                    end
                    r_state <= t_WR;
                end
                t_WR: begin
                    r_state <= t_EMIT;
                end
                t_EMIT: begin
                    if (w_free) begin
                        r_ovalid <= 1'b1;
                        r_ox <= r_px[21:0];
                        r_oy <= r_py[21:0];
                        r_oz <= r_pz[21:0];
                        r_ocol <= 6'(r_col);
                        r_orow <= 6'(r_row);
                        r_oslc <= 6'(r_slc);
                        r_ocnt <= 20'(r_cnt);
                        r_state <= t_IDLE;
                    end
                end
                default: r_state <= t_IDLE;
            endcase
        end
    end

    logic w_unused;
    assign w_unused = ^{r_oor, r_rem[0]};
endmodule
`default_nettype wire

// ===== tb/tb_sphere_surface_sampler_voxel_histogram_top.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_sphere_surface_sampler_voxel_histogram_top;
    import sssvh_pkg::*;

    localparam logic [1:0] RadiusAddr = 2'(RegRadius * 4);
    localparam longint Half63 = 63 * 32768;

    // Arctangent of 2^-i as a fraction of one turn, 2^32 per turn.
    localparam longint AtanTurn [30] = '{
        'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
        'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
        'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
        'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051,
        'h00000029, 'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001
    };

    typedef struct {
        logic signed [21:0] px;
        logic signed [21:0] py;
        logic signed [21:0] pz;
        logic [5:0]  col;
        logic [5:0]  row;
        logic [5:0]  slc;
        logic [19:0] count;
    } voxel_result_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    sssvh_in_if  in_if ();
    sssvh_out_if out_if ();

    sphere_surface_sampler_voxel_histogram_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #10 i_clk = ~i_clk;

    // Shadow state of the block and the results still owed by it.
    bit [19:0]     hit_counts [int];
    int            hit_voxels [$];
    logic [4:0]    radius = 5'd20;
    voxel_result_t pending_results [$];
    int            errors = 0;
    int            n_samples = 0;
    int            n_reads = 0;
    int            n_checked = 0;
    int            send_idle_pct = 0;
    int            stall_pct = 0;

    initial begin
        in_if.valid = 1'b0;
        in_if.action = t_ACT_SAMPLE;
        in_if.uniform_height = '0;
        in_if.uniform_angle = '0;
        in_if.voxel_address = '0;
        out_if.ready = 1'b0;
    end

    // Floor square root of a 64-bit word, bit by bit.
    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned r = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Cosine and sine of the azimuth in Q.30 by fixed-length CORDIC.
    function automatic void azimuth_sincos(input bit [31:0] k, output longint cs,
                                           output longint sn);
        bit [32:0] phase = {k, 1'b1};
        longint z = longint'(phase[30:0]);
        longint x = longint'(CordicGain);
        longint y = 0;
        longint nx;
        for (int i = 0; i < CordicSteps; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= 2 * AtanTurn[i];
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += 2 * AtanTurn[i];
            end
            x = nx;
        end
        case (phase[32:31])
            2'd0: begin cs = x;  sn = y;  end
            2'd1: begin cs = -y; sn = x;  end
            2'd2: begin cs = -x; sn = -y; end
            default: begin cs = y; sn = -x; end
        endcase
    endfunction

    function automatic longint round_q(input longint v, input int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint to_index(input longint q16, input int size);
        return clamp(q16 >>> 16, 0, size - 1);
    endfunction

    // Expected result of one transaction; a sample also updates the shadow histogram.
    function automatic voxel_result_t predict_voxel(input t_action act, input bit [31:0] kh,
                                                    input bit [31:0] ka,
                                                    input bit [17:0] addr);
        voxel_result_t res;
        longint r = longint'(radius);
        longint lim = r <<< 16;
        longint cq, s, cs, sn, px, py, pz, col, row, slc;
        longint unsigned mag;
        int idx;
        if (act == t_ACT_READ) begin
            res.px = '0;
            res.py = '0;
            res.pz = '0;
            res.col = addr[5:0];
            res.row = addr[11:6];
            res.slc = addr[17:12];
            res.count = hit_counts.exists(int'(addr)) ? hit_counts[int'(addr)] : '0;
            return res;
        end
        cq = 2 * longint'(kh) + 1 - (64'sd1 <<< 32);
        mag = cq < 0 ? -cq : cq;
        s = longint'(floor_sqrt(64'd0 - mag * mag));
        azimuth_sincos(ka, cs, sn);
        px = clamp(round_q(round_q(s * cs, 32) * r, 14), -lim, lim);
        py = clamp(round_q(round_q(s * sn, 32) * r, 14), -lim, lim);
        pz = clamp(round_q(cq * r, 16), -lim, lim);
        col = to_index(px + Half63, GridWidth);
        row = to_index(Half63 - py, GridHeight);
        slc = to_index(Half63 - pz, GridDepth);
        idx = int'(slc * GridWidth * GridHeight + row * GridWidth + col);
        if (!hit_counts.exists(idx)) begin
            hit_counts[idx] = '0;
            hit_voxels.push_back(idx);
        end
        if (hit_counts[idx] != CountMax) hit_counts[idx] = hit_counts[idx] + 1'b1;
        res.px = px[21:0];
        res.py = py[21:0];
        res.pz = pz[21:0];
        res.col = col[5:0];
        res.row = row[5:0];
        res.slc = slc[5:0];
        res.count = hit_counts[idx];
        return res;
    endfunction

    // Offer one transaction, idling first at random, and record what it must return.
    task automatic send_item(input t_action act, input bit [31:0] kh, input bit [31:0] ka,
                             input bit [17:0] addr);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.action <= act;
        in_if.uniform_height <= kh;
        in_if.uniform_angle <= ka;
        in_if.voxel_address <= addr;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        pending_results.push_back(predict_voxel(act, kh, ka, addr));
        if (act == t_ACT_READ) n_reads++;
        else n_samples++;
    endtask

    task automatic send_sample(input bit [31:0] kh, input bit [31:0] ka);
        send_item(t_ACT_SAMPLE, kh, ka, 18'($urandom));
    endtask

    task automatic send_read(input bit [17:0] addr);
        send_item(t_ACT_READ, $urandom, $urandom, addr);
    endtask

    // Stop offering and let every outstanding result come back.
    task automatic drain_results();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Write the radius over the register port and read it back.
    task automatic set_radius(input logic [4:0] value);
        drain_results();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= RadiusAddr;
        pwdata <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        radius = value;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[4:0] !== value) begin
            $error("radius_scale readback: expected %0d, got %0d", value, prdata[4:0]);
            errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // Receiver back-pressure.
    always @(posedge i_clk) out_if.ready <= ($urandom_range(99) >= stall_pct);

    // Compare every result transaction with the oldest expectation.
    always @(posedge i_clk) begin
        voxel_result_t want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with no expectation waiting");
                errors++;
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                check_field("point_x", want.px, out_if.point_x);
                check_field("point_y", want.py, out_if.point_y);
                check_field("point_z", want.pz, out_if.point_z);
                check_field("voxel_column", want.col, out_if.voxel_column);
                check_field("voxel_row", want.row, out_if.voxel_row);
                check_field("voxel_slice", want.slc, out_if.voxel_slice);
                check_field("voxel_count", want.count, out_if.voxel_count);
            end
        end
    end

    // Poles, equator, quadrant boundaries and extreme words at the reset radius.
    task automatic test_directed_points();
        send_sample(32'h0000_0000, 32'h0000_0000);
        send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_sample(32'h7FFF_FFFF, 32'h0000_0000);
        send_sample(32'h8000_0000, 32'h4000_0000);
        send_sample(32'h7FFF_FFFF, 32'h8000_0000);
        send_sample(32'h8000_0000, 32'hC000_0000);
        send_sample(32'h7FFF_FFFF, 32'h3FFF_FFFF);
        send_sample(32'h8000_0000, 32'hBFFF_FFFF);
        send_sample(32'h5555_5555, 32'hAAAA_AAAA);
        send_sample(32'hAAAA_AAAA, 32'h5555_5555);
        // The same point twice must count up in one voxel.
        send_sample(32'h7FFF_FFFF, 32'h0000_0000);
        send_read(18'h3FFFF);
        send_read(18'h00000);
        if (hit_voxels.size() != 0) send_read(18'(hit_voxels[0]));
    endtask

    // Zero, smallest and largest radius: overshoot and index clamping live here.
    task automatic test_radius_extremes();
        logic [4:0] radii [3] = '{5'd0, 5'd1, 5'd31};
        foreach (radii[i]) begin
            set_radius(radii[i]);
            send_sample(32'h0000_0000, 32'h0000_0000);
            send_sample(32'hFFFF_FFFF, 32'h2000_0000);
            send_sample(32'h8000_0000, 32'h0000_0000);
            send_sample(32'h7FFF_FFFF, 32'hE000_0000);
        end
    endtask

    // Mixed samples and reads under one idling and stall pattern at one radius.
    task automatic test_random_traffic(input int items, input int idle_pct,
                                       input int stall, input logic [4:0] rad);
        bit [31:0] kh;
        set_radius(rad);
        send_idle_pct = idle_pct;
        stall_pct = stall;
        for (int n = 0; n < items; n++) begin
            if ($urandom_range(99) < 70) begin
                kh = $urandom;
                if ($urandom_range(9) == 0) kh = $urandom_range(1) ? kh >> 24 : ~(kh >> 24);
                send_sample(kh, $urandom);
            end else if ($urandom_range(2) != 0 && hit_voxels.size() != 0) begin
                send_read(18'(hit_voxels[$urandom_range(hit_voxels.size() - 1)]));
            end else begin
                send_read(18'($urandom));
            end
        end
        drain_results();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_points();
        test_radius_extremes();
        test_random_traffic(325, 0, 0, 5'd20);
        test_random_traffic(325, 84, 0, 5'($urandom_range(30, 1)));
        test_random_traffic(325, 0, 84, 5'd1);
        test_random_traffic(325, 15, 15, 5'd31);
        drain_results();
        $display("Covered %0d samples and %0d voxel reads, %0d results checked,",
                 n_samples, n_reads, n_checked);
        $display("over radii 0, 1, 20 and 31 with sender gaps and receiver stalls.");
        if (errors == 0 && pending_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Guard against a hang; allows for the histogram clearing pass after reset.
    initial begin
        #60_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire
